// ----- hdl/irtc_pkg.sv -----
// ----------------------------------------------------------------------------
// irtc_pkg
// Shared constants, types and helpers of the integer radix text converter.
// ----------------------------------------------------------------------------
package irtc_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int RADIX_W        = 6;
    localparam int CHAR_W         = 8;
    localparam int HEAD_MAX       = 6;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    // configuration register indexes
    localparam logic [0:0] CFG_RADIX     = 1'b0;
    localparam logic [0:0] CFG_SHOW_PLUS = 1'b1;

    localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7b;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7d;
    localparam logic [CHAR_W-1:0] CH_B      = 8'h62;
    localparam logic [CHAR_W-1:0] CH_O      = 8'h6f;
    localparam logic [CHAR_W-1:0] CH_X      = 8'h78;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;

    typedef struct packed {
        logic               done;
        logic               quo_zero;
        logic [RADIX_W-1:0] digit;
    } t_div_stat;

    typedef struct packed {
        logic              any;
        logic              one_left;
        logic [CHAR_W-1:0] ch;
    } t_head_stat;

    // map a digit value 0..35 onto 0-9, a-z
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 6'd10) begin
            c = CH_ZERO + {2'b00, d};
        end else begin
            c = 8'h57 + {2'b00, d};
        end
        return c;
    endfunction

endpackage

// ----- hdl/irtc_serial_div.sv -----
// ----------------------------------------------------------------------------
// irtc_serial_div
// Bit-serial restoring divider: one quotient bit per cycle, small remainder.
// ----------------------------------------------------------------------------
module irtc_serial_div
    import irtc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic                  i_cont,
    input  logic [VALUE_BITS-1:0] i_dividend,
    input  logic [RADIX_W-1:0]    i_base,
    output t_div_stat             o_stat
);

    localparam int SW = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] r_quo;
    logic [RADIX_W-1:0]    r_rem;
    logic [RADIX_W-1:0]    r_base;
    logic [SW-1:0]         r_step;
    logic                  r_run;
    logic                  r_done;

    logic [RADIX_W:0] w_trial;
    logic [RADIX_W:0] w_diff;
    logic             w_ge;

    assign w_trial = {r_rem, r_quo[VALUE_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_base};
    assign w_ge    = (w_trial >= {1'b0, r_base});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_run && (r_step == '0);
            if (i_load || i_cont) begin
                r_run  <= 1'b1;
                r_step <= SW'(VALUE_BITS - 1);
            end else if (r_run) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quo  <= i_dividend;
            r_base <= i_base;
            r_rem  <= '0;
        end else if (i_cont) begin
            r_rem <= '0;
        end else if (r_run) begin
            // shift one dividend bit in, one quotient bit out
            r_quo <= {r_quo[VALUE_BITS-2:0], w_ge};
            r_rem <= w_ge ? w_diff[RADIX_W-1:0] : w_trial[RADIX_W-1:0];
        end
    end

    assign o_stat.done     = r_done;
    assign o_stat.quo_zero = (r_quo == '0);
    assign o_stat.digit    = r_rem;

endmodule

// ----- hdl/irtc_digit_stack.sv -----
// ----------------------------------------------------------------------------
// irtc_digit_stack
// Digit store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module irtc_digit_stack
    import irtc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(VALUE_BITS)-1:0] i_waddr,
    input  logic [RADIX_W-1:0]            i_wdata,
    input  logic                          i_re,
    input  logic [$clog2(VALUE_BITS)-1:0] i_raddr,
    output logic [RADIX_W-1:0]            o_rdata
);

    logic [RADIX_W-1:0] r_mem [VALUE_BITS];
    logic [RADIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/irtc_head.sv -----
// ----------------------------------------------------------------------------
// irtc_head
// Builds the prefix and sign characters and shifts them out one per cycle while i_shift is high.
// ----------------------------------------------------------------------------
module irtc_head
    import irtc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic [RADIX_W-1:0] i_base,
    input  logic               i_neg,
    input  logic               i_zero,
    input  logic               i_show_plus,
    input  logic               i_shift,
    output t_head_stat         o_stat
);

    logic [CHAR_W-1:0] r_chars [HEAD_MAX];
    logic [2:0]        r_len;

    logic [CHAR_W-1:0] w_pre [HEAD_MAX];
    logic [CHAR_W-1:0] w_chars [HEAD_MAX];
    logic [2:0]        w_plen;
    logic [2:0]        w_len;
    logic [1:0]        w_tens;
    logic [RADIX_W-1:0] w_ones;
    logic              w_sign;
    logic [CHAR_W-1:0] w_sign_ch;

    always_comb begin
        if (i_base >= 6'd30) begin
            w_tens = 2'd3;
            w_ones = i_base - 6'd30;
        end else if (i_base >= 6'd20) begin
            w_tens = 2'd2;
            w_ones = i_base - 6'd20;
        end else if (i_base >= 6'd10) begin
            w_tens = 2'd1;
            w_ones = i_base - 6'd10;
        end else begin
            w_tens = 2'd0;
            w_ones = i_base;
        end
    end

    always_comb begin
        for (int i = 0; i < HEAD_MAX; i++) begin
            w_pre[i] = '0;
        end
        w_pre[0] = CH_HASH;
        w_plen   = 3'd2;
        if (i_base == 6'd2) begin
            w_pre[1] = CH_B;
        end else if (i_base == 6'd8) begin
            w_pre[1] = CH_O;
        end else if (i_base == 6'd16) begin
            w_pre[1] = CH_X;
        end else if (i_base == 6'd10) begin
            w_plen = 3'd0;
        end else if (w_tens == 2'd0) begin
            w_pre[1] = CH_LBRACE;
            w_pre[2] = digit_char(w_ones);
            w_pre[3] = CH_RBRACE;
            w_plen   = 3'd4;
        end else begin
            w_pre[1] = CH_LBRACE;
            w_pre[2] = digit_char({4'd0, w_tens});
            w_pre[3] = digit_char(w_ones);
            w_pre[4] = CH_RBRACE;
            w_plen   = 3'd5;
        end
    end

    // zero shows '+' only in bases 8, 10 and 16
    assign w_sign = i_neg || (i_show_plus && (!i_zero || i_base == 6'd8 ||
                    i_base == 6'd10 || i_base == 6'd16));
    assign w_sign_ch = i_neg ? CH_MINUS : CH_PLUS;
    assign w_len     = w_plen + {2'b00, w_sign};

    always_comb begin
        for (int i = 0; i < HEAD_MAX; i++) begin
            if (3'(i) < w_plen) begin
                w_chars[i] = w_pre[i];
            end else if (3'(i) == w_plen) begin
                w_chars[i] = w_sign_ch;
            end else begin
                w_chars[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_load) begin
            r_len <= w_len;
        end else if (i_shift && r_len != '0) begin
            r_len <= r_len - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_chars <= w_chars;
        end else if (i_shift) begin
            for (int i = 0; i < HEAD_MAX - 1; i++) begin
                r_chars[i] <= r_chars[i+1];
            end
            r_chars[HEAD_MAX-1] <= '0;
        end
    end

    assign o_stat.any      = (r_len != '0);
    assign o_stat.one_left = (r_len == 3'd1);
    assign o_stat.ch       = r_chars[0];

endmodule

// ----- hdl/integer_radix_text_converter_unit.sv -----
// ----------------------------------------------------------------------------
// integer_radix_text_converter_unit
// Formats one signed integer as radix text, one ASCII character per cycle while o_strobe is high.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with i_value while busy is low; the transaction is taken at
//   that edge. The block then drives the text on o_text_char, one character
//   per o_strobe cycle, and raises o_last on the final character. The
//   receiver takes each character in the cycle it is shown and cannot stall.
//   Text is prefix (#b, #o, #x, none for base 10, #{N} otherwise), sign, then
//   digits most significant first in lower case.
//   i_cfg_we/i_cfg_idx/i_cfg_data write radix (index 0) and show_plus
//   (index 1); write them only while busy is low.
// Timing:
//   Prefix and sign leave first at one per cycle while the first division
//   runs. Each digit takes a full pass of the bit-serial divider, one
//   quotient bit per cycle. After the last division the digits stream out
//   at one per cycle through the stack read register and the output register.
//   A new start is taken only once busy falls, after the last digit has been
//   read from the stack.
// Reset: synchronous, active low; radix returns to 10, show_plus to 0 and any
//   transaction in flight is dropped.
// ----------------------------------------------------------------------------
module integer_radix_text_converter_unit
    import irtc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic                         i_cfg_we,
    input  logic [0:0]                   i_cfg_idx,
    input  logic [RADIX_W-1:0]           i_cfg_data,
    output logic                         o_strobe,
    output logic [CHAR_W-1:0]            o_text_char,
    output logic                         o_last
);

    localparam int AW = $clog2(VALUE_BITS);
    localparam int CW = $clog2(VALUE_BITS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HEAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [RADIX_W-1:0] r_radix;
    logic               r_show_plus;
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      n_cnt;
    logic               r_rd_v;
    logic               r_rd_last;
    logic               r_out_stb;
    logic [CHAR_W-1:0]  r_out_char;
    logic               r_out_last;

    logic                  w_take;
    logic [VALUE_BITS-1:0] w_raw;
    logic [VALUE_BITS-1:0] w_mag;
    logic                  w_neg;
    logic [RADIX_W-1:0]    w_base;
    logic                  w_cont;
    logic                  w_push;
    logic                  w_pop;
    logic                  w_shift;
    logic [CW-1:0]         w_cnt_dec;
    logic [RADIX_W-1:0]    w_rdata;
    t_div_stat             w_div;
    t_head_stat            w_head;

    assign w_take    = start && !busy;
    assign w_raw     = $unsigned(i_value);
    assign w_neg     = w_raw[VALUE_BITS-1];
    assign w_mag     = w_neg ? (VALUE_BITS'(0) - w_raw) : w_raw;
    assign w_base    = (r_radix < 6'd2 || r_radix > 6'd36) ? 6'd10 : r_radix;
    assign w_cnt_dec = r_cnt - 1'b1;

    assign w_shift = (r_state == ST_HEAD) && w_head.any;
    assign w_push  = (r_state == ST_DIV) && w_div.done;
    assign w_cont  = w_push && !w_div.quo_zero;
    assign w_pop   = (r_state == ST_EMIT);

    assign busy = (r_state != ST_IDLE) || r_rd_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix     <= RADIX_RESET;
            r_show_plus <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RADIX:     r_radix     <= i_cfg_data;
                CFG_SHOW_PLUS: r_show_plus <= i_cfg_data[0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    n_state = ST_HEAD;
                    n_cnt   = '0;
                end
            end
            ST_HEAD: begin
                if (!w_head.any || w_head.one_left) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div.done) begin
                    n_cnt = r_cnt + 1'b1;
                    if (w_div.quo_zero) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                n_cnt = w_cnt_dec;
                if (r_cnt == CW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_rd_v    <= 1'b0;
            r_out_stb <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_rd_v    <= w_pop;
            r_out_stb <= w_shift || r_rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_last  <= (r_cnt == CW'(1));
        r_out_char <= r_rd_v ? digit_char(w_rdata) : w_head.ch;
        r_out_last <= r_rd_v && r_rd_last;
    end

    irtc_serial_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_take),
        .i_cont     (w_cont),
        .i_dividend (w_mag),
        .i_base     (w_base),
        .o_stat     (w_div)
    );

    irtc_head u_head (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_take),
        .i_base      (w_base),
        .i_neg       (w_neg),
        .i_zero      (w_raw == '0),
        .i_show_plus (r_show_plus),
        .i_shift     (w_shift),
        .o_stat      (w_head)
    );

    irtc_digit_stack #(
        .VALUE_BITS (VALUE_BITS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (w_div.digit),
        .i_re    (w_pop),
        .i_raddr (w_cnt_dec[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign o_strobe    = r_out_stb;
    assign o_text_char = r_out_char;
    assign o_last      = r_out_last;

`ifndef NO_ASSERTIONS
    // a division pass outlasts the longest prefix and sign
    a_no_done_in_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HEAD) |-> !w_div.done)
        else $error("division finished while prefix still shifting");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(VALUE_BITS))
        else $error("digit count beyond stack depth");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("character right after final character");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_cnt != '0))
        else $error("digit output with empty stack");
`endif

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Checks integer_radix_text_converter_unit: each accepted value is formatted
// by a local predictor under the current radix and sign settings, and every
// character the block strobes out is compared with the oldest one expected.
// ----------------------------------------------------------------------------
module tb;
    import irtc_pkg::*;

    localparam int  VBITS       = 32;
    localparam int  CYCLE_LIMIT = 4000000;
    localparam int  DRAIN_WAIT  = 400;
    localparam int  RAND_PHASES = 10;
    localparam int  PHASE_ITEMS = 50;

    localparam logic [VBITS-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [VBITS-1:0] VAL_MAX = 32'h7fff_ffff;

    class text_scoreboard;
        typedef struct {
            logic [CHAR_W-1:0] ch;
            logic              last;
        } t_text_item;

        logic [RADIX_W-1:0] radix;
        logic               show_plus;
        t_text_item         chars_q[$];
        int                 mismatches;
        int                 values_seen;
        int                 chars_seen;

        function new();
            radix       = RADIX_RESET;
            show_plus   = 1'b0;
            mismatches  = 0;
            values_seen = 0;
            chars_seen  = 0;
        endfunction

        function void write_reg(logic [0:0] idx, logic [RADIX_W-1:0] data);
            if (idx == CFG_RADIX) begin
                radix = data;
            end else begin
                show_plus = data[0];
            end
        endfunction

        function void push_char(logic [CHAR_W-1:0] c);
            t_text_item t;
            t.ch   = c;
            t.last = 1'b0;
            chars_q.push_back(t);
        endfunction

        // Format one value and queue its characters.
        function void note_value(logic [VBITS-1:0] v);
            int unsigned       base;
            logic              neg;
            logic [VBITS-1:0]  mag;
            logic [RADIX_W-1:0] digits[$];
            logic [RADIX_W-1:0] d;
            values_seen++;
            base = radix;
            if (base < 2 || base > 36) begin
                base = 10;
            end
            case (base)
                2: begin
                    push_char(CH_HASH);
                    push_char(CH_B);
                end
                8: begin
                    push_char(CH_HASH);
                    push_char(CH_O);
                end
                16: begin
                    push_char(CH_HASH);
                    push_char(CH_X);
                end
                10: ;
                default: begin
                    push_char(CH_HASH);
                    push_char(CH_LBRACE);
                    if (base >= 10) begin
                        push_char(CH_ZERO + CHAR_W'(base / 10));
                    end
                    push_char(CH_ZERO + CHAR_W'(base % 10));
                    push_char(CH_RBRACE);
                end
            endcase
            neg = v[VBITS-1];
            if (neg) begin
                push_char(CH_MINUS);
                mag = ~v + 1'b1;
            end else begin
                mag = v;
                // zero gets a plus only in bases 8, 10 and 16
                if (show_plus && (v != 0 || base == 8 || base == 10 || base == 16)) begin
                    push_char(CH_PLUS);
                end
            end
            if (mag == 0) begin
                digits.push_front('0);
            end
            while (mag != 0) begin
                digits.push_front(RADIX_W'(mag % base));
                mag = mag / base;
            end
            foreach (digits[i]) begin
                d = digits[i];
                if (d < 10) begin
                    push_char(CH_ZERO + {2'b00, d});
                end else begin
                    push_char(8'h61 + {2'b00, d} - 8'd10);
                end
            end
            chars_q[chars_q.size() - 1].last = 1'b1;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("MISMATCH: %s", msg);
            end
        endfunction

        function void check_char(logic [CHAR_W-1:0] ch, logic last);
            t_text_item exp_item;
            chars_seen++;
            if (chars_q.size() == 0) begin
                flag($sformatf("unexpected char 8'h%02h last=%0b", ch, last));
                return;
            end
            exp_item = chars_q.pop_front();
            if (ch !== exp_item.ch || last !== exp_item.last) begin
                flag($sformatf("char exp 8'h%02h got 8'h%02h, last exp %0b got %0b",
                               exp_item.ch, ch, exp_item.last, last));
            end
        endfunction

        function int waiting();
            return chars_q.size();
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic signed [VBITS-1:0]  i_value;
    logic                     i_cfg_we;
    logic [0:0]               i_cfg_idx;
    logic [RADIX_W-1:0]       i_cfg_data;
    logic                     o_strobe;
    logic [CHAR_W-1:0]        o_text_char;
    logic                     o_last;

    text_scoreboard sb = new();
    int             cycle_count = 0;
    int             settings_used = 0;
    bit             steady_phase;

    integer_radix_text_converter_unit #(.VALUE_BITS(VBITS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_text_char (o_text_char),
        .o_last      (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check_char(o_text_char, o_last);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d chars still expected",
                     cycle_count, sb.waiting());
            $display("tb NOT OK");
            $finish;
        end
    end

    // Hold start until the transaction is taken, then idle for a gap set by gap (none if gap is zero).
    task automatic send_value(logic [VBITS-1:0] v, int gap);
        @(negedge i_clk);
        start   <= 1'b1;
        i_value <= v;
        forever begin
            @(posedge i_clk);
            if (!busy) begin
                break;
            end
        end
        sb.note_value(v);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.waiting() != 0 || busy) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [0:0] idx, logic [RADIX_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_config(logic [RADIX_W-1:0] radix, logic plus);
        settle();
        write_reg(CFG_RADIX, radix);
        // upper data bits are don't-care for the sign register; toggle them anyway
        write_reg(CFG_SHOW_PLUS, {RADIX_W'($urandom_range(0, 31)) << 1} | RADIX_W'(plus));
        settings_used++;
    endtask

    function automatic logic [RADIX_W-1:0] pick_radix();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0: return 6'd2;
            1: return 6'd8;
            2: return 6'd16;
            3: return 6'd10;
            9: begin
                if ($urandom_range(0, 1) == 0) begin
                    return RADIX_W'($urandom_range(0, 1));
                end
                return RADIX_W'($urandom_range(37, 63));
            end
            default: return RADIX_W'($urandom_range(2, 36));
        endcase
    endfunction

    function automatic logic [VBITS-1:0] pick_value();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0: return '0;
            1: return VBITS'($urandom_range(1, 50));
            2: return -VBITS'($urandom_range(1, 50));
            3: begin
                case ($urandom_range(0, 3))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return VAL_MIN + 1'b1;
                    default: return '1;
                endcase
            end
            default: return VBITS'($urandom());
        endcase
    endfunction

    function automatic int pick_gap();
        if (steady_phase || $urandom_range(0, 9) < 6) begin
            return steady_phase ? 0 : $urandom_range(0, 2);
        end
        if ($urandom_range(0, 4) == 0) begin
            return $urandom_range(20, 120);
        end
        return $urandom_range(3, 10);
    endfunction

    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_value    = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        steady_phase = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: decimal, no plus
        send_value('0, 0);
        send_value(32'd1, 1);
        send_value('1, 0);
        send_value(VAL_MAX, 3);
        send_value(VAL_MIN, 0);

        // longest text: binary of the most negative value
        apply_config(6'd2, 1'b1);
        send_value('0, 0);
        send_value(32'd1, 0);
        send_value(VAL_MIN, 2);
        send_value(VAL_MAX, 0);

        apply_config(6'd8, 1'b1);
        send_value('0, 0);
        send_value(-32'sd8, 0);

        apply_config(6'd16, 1'b1);
        send_value('0, 1);
        send_value(32'hdead_beef, 0);
        send_value(32'd255, 0);

        apply_config(6'd36, 1'b1);
        send_value('0, 0);
        send_value(VAL_MIN, 0);
        send_value(32'd35, 0);

        apply_config(6'd3, 1'b0);
        send_value('0, 0);
        send_value(-32'sd5, 0);

        // out-of-range radix falls back to decimal
        apply_config(6'd0, 1'b1);
        send_value('0, 0);
        send_value(32'd123, 0);
        apply_config(6'd63, 1'b0);
        send_value(-32'sd42, 0);
        apply_config(6'd1, 1'b1);
        send_value(32'd7, 0);
        apply_config(6'd37, 1'b1);
        send_value('0, 0);

        for (int p = 0; p < RAND_PHASES; p++) begin
            apply_config(pick_radix(), 1'($urandom_range(0, 1)));
            steady_phase = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_value(pick_value(), pick_gap());
            end
        end

        settle();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.waiting() != 0) begin
            sb.flag($sformatf("%0d expected chars never arrived", sb.waiting()));
        end
        $display("converted %0d values into %0d characters over %0d register settings",
                 sb.values_seen, sb.chars_seen, settings_used);
        $display("mismatches: %0d, cycles: %0d", sb.mismatches, cycle_count);
        if (sb.mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
